// File: rtl/core/fipa_pkg.sv
// Shared types and constants of the free index pool allocator.
package fipa_pkg;

	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE     = 2'd1,
		OP_FREE_ALL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

endpackage

// File: rtl/core/fipa_free_list.sv
// Free list storage: one write port, one registered read port.
module fipa_free_list #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [fipa_pkg::IDX_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [fipa_pkg::IDX_W-1:0] rdata
);
	import fipa_pkg::*;

	logic [IDX_W-1:0] mem_q [DEPTH];
	logic [IDX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/free_index_pool_allocator_top.sv
// Top level of the free index pool allocator: stack control, result stage, output register.
//
// Takes one request per cycle unless the output stalls; its result passes through the result stage
// into the output register, and a finished result waiting there does not stop one more request
// from entering the result stage.
// The registered read port of the free-list memory sets the extra stage; a pop reads the entry
// below the top pointer as the request is taken. Free-all writes no memory entry: a
// low-water mark records how far the stack has dropped since the last refill, and an entry
// below that mark reads as its refill value (refill capacity - 1 - position) instead of from the
// memory, so no clearing pass runs after reset or free-all. Allocation pops the most recently
// freed index; after reset or free-all index 0 comes out first. A new capacity applies fully at
// the next free-all.
module free_index_pool_allocator_top #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 operation,
	input  logic [fipa_pkg::IDX_W-1:0] index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fipa_pkg::IDX_W-1:0] granted_index,
	output logic [1:0]                 status,
	output logic [fipa_pkg::CNT_W-1:0] free_count,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fipa_pkg::CNT_W-1:0] capacity
);
	import fipa_pkg::*;

	localparam int LIM = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
	localparam int AW  = $clog2(LIM);
	localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] top_q;
	logic [CNT_W-1:0] lw_q;
	logic [CNT_W-1:0] fill_q;

	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] top_m1;
	logic [CNT_W-1:0] top_n;
	logic [CNT_W-1:0] lw_n;
	logic [CNT_W-1:0] fill_n;
	logic [CNT_W-1:0] refill_diff;
	status_t          st_c;
	logic             pop_ok_c;
	logic             use_mem_c;
	logic             we_c;
	logic             re_c;
	logic             accept;
	logic             adv;
	logic [IDX_W-1:0] rdata;

	logic             valid_s1;
	status_t          status_s1;
	logic             pop_ok_s1;
	logic             use_mem_s1;
	logic [IDX_W-1:0] rst_val_s1;
	logic [CNT_W-1:0] count_s1;

	logic             out_valid_q;
	logic [IDX_W-1:0] granted_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;

	// saturate the capacity register to 1 .. LIM
	always_comb begin
		cap = capacity_q;
		if (capacity_q == '0) begin
			cap = CNT_W'(1);
		end else if (capacity_q > LIM_C) begin
			cap = LIM_C;
		end
	end

	assign top_m1      = top_q - CNT_W'(1);
	assign refill_diff = fill_q - top_q;

	always_comb begin
		top_n     = top_q;
		lw_n      = lw_q;
		fill_n    = fill_q;
		st_c      = ST_OK;
		pop_ok_c  = 1'b0;
		use_mem_c = 1'b0;
		we_c      = 1'b0;
		re_c      = 1'b0;
		case (operation)
			OP_ALLOC: begin
				if (top_q == '0) begin
					st_c = ST_EMPTY;
				end else begin
					top_n     = top_m1;
					re_c      = 1'b1;
					pop_ok_c  = 1'b1;
					// entry untouched since refill unless the stack dropped to it before
					use_mem_c = (top_m1 >= lw_q);
					if (top_m1 < lw_q) begin
						lw_n = top_m1;
					end
				end
			end
			OP_FREE: begin
				if ({1'b0, index} >= cap) begin
					st_c = ST_RANGE;
				end else if (top_q >= cap) begin
					st_c = ST_FULL;
				end else begin
					we_c  = 1'b1;
					top_n = top_q + CNT_W'(1);
				end
			end
			OP_FREE_ALL: begin
				top_n  = cap;
				lw_n   = cap;
				fill_n = cap;
			end
			default: begin
			end
		endcase
	end

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	fipa_free_list #(
		.DEPTH (LIM),
		.AW    (AW)
	) u_free_list (
		.clk   (clk),
		.we    (accept && we_c),
		.waddr (top_q[AW-1:0]),
		.wdata (index),
		.re    (accept && re_c),
		.raddr (top_m1[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			top_q      <= LIM_C;
			lw_q       <= LIM_C;
			fill_q     <= LIM_C;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= capacity;
			end
			if (accept) begin
				top_q  <= top_n;
				lw_q   <= lw_n;
				fill_q <= fill_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// request stage waits here for the memory read data
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= st_c;
			pop_ok_s1  <= pop_ok_c;
			use_mem_s1 <= use_mem_c;
			rst_val_s1 <= refill_diff[IDX_W-1:0];
			count_s1   <= top_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			granted_q <= pop_ok_s1 ? (use_mem_s1 ? rdata : rst_val_s1) : '0;
			status_q  <= status_s1;
			count_q   <= count_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted_index = granted_q;
	assign status        = status_q;
	assign free_count    = count_q;

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= LIM_C)
		else $error("free list top beyond storage depth");

	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lw_q <= fill_q)
		else $error("low-water mark above refill capacity");

	a_accept_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach the result stage");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |=> valid_s1)
		else $error("pending request dropped while output stalled");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> granted_q == '0)
		else $error("rejected request returned a nonzero index");

endmodule

// File: test/tb_top.sv
// Testbench for the free index pool allocator: directed table plus random requests.
`timescale 1ns / 1ps

module tb_top;
	import fipa_pkg::*;

	localparam int POOL_MAX = 256;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 60;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0] granted;
		status_t          stat;
		logic [CNT_W-1:0] count;
	} grant_t;

	typedef struct {
		bit               is_cfg;
		logic [CNT_W-1:0] cap;
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		bit               typed;
		grant_t           want;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       operation;
	logic [IDX_W-1:0] index;
	logic             out_valid;
	logic             out_ready;
	logic [IDX_W-1:0] granted_index;
	logic [1:0]       status;
	logic [CNT_W-1:0] free_count;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] capacity;

	// pool mirror
	logic [CNT_W-1:0] pool_capacity;
	logic [IDX_W-1:0] free_stack [POOL_MAX];
	int unsigned      free_top;
	grant_t           awaited_grants [$];

	bit     row_typed;
	grant_t row_want;
	bit     quiet_phase;
	int     error_count;
	int     cycle_count;
	stim_row_t directed_rows [$];

	free_index_pool_allocator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.index         (index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.granted_index (granted_index),
		.status        (status),
		.free_count    (free_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.capacity      (capacity)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned pool_limit();
		if (pool_capacity == 0) return 1;
		if (pool_capacity > POOL_MAX) return POOL_MAX;
		return pool_capacity;
	endfunction

	function automatic void pool_refill();
		int unsigned lim;
		lim = pool_limit();
		for (int k = 0; k < POOL_MAX; k++)
			free_stack[k] = (k < lim) ? IDX_W'(lim - 1 - k) : '0;
		free_top = lim;
	endfunction

	function automatic grant_t predict_grant(input logic [1:0] op, input logic [IDX_W-1:0] idx);
		grant_t res;
		int unsigned lim;
		lim = pool_limit();
		res.granted = '0;
		res.stat = ST_OK;
		case (op)
			OP_ALLOC: begin
				if (free_top == 0) begin
					res.stat = ST_EMPTY;
				end else begin
					free_top--;
					res.granted = free_stack[free_top];
				end
			end
			OP_FREE: begin
				if (idx >= lim) begin
					res.stat = ST_RANGE;
				end else if (free_top >= lim) begin
					res.stat = ST_FULL;
				end else begin
					free_stack[free_top] = idx;
					free_top++;
				end
			end
			OP_FREE_ALL: begin
				pool_refill();
			end
			default: begin
			end
		endcase
		res.count = CNT_W'(free_top);
		return res;
	endfunction

	function automatic stim_row_t req_row(input logic [1:0] op, input logic [IDX_W-1:0] idx);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.cap = '0;
		r.op = op;
		r.idx = idx;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t chk_row(input logic [1:0] op, input logic [IDX_W-1:0] idx,
			input logic [IDX_W-1:0] g, input status_t st, input logic [CNT_W-1:0] cnt);
		stim_row_t r;
		r = req_row(op, idx);
		r.typed = 1'b1;
		r.want.granted = g;
		r.want.stat = st;
		r.want.count = cnt;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CNT_W-1:0] cap);
		stim_row_t r;
		r = req_row(OP_ALLOC, '0);
		r.is_cfg = 1'b1;
		r.cap = cap;
		return r;
	endfunction

	function automatic int draw_wait();
		return quiet_phase ? 0 : $urandom_range(0, 6);
	endfunction

	// compare results first, then record the request taken at this edge
	always @(posedge clk) begin : scoreboard
		grant_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_grants.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result: granted %0d status %0d count %0d",
							granted_index, status, free_count);
				end else begin
					want = awaited_grants.pop_front();
					if (granted_index !== want.granted || status !== want.stat ||
							free_count !== want.count) begin
						error_count++;
						if (error_count <= 10)
							$display("result mismatch: expected granted %0d status %0d count %0d, got granted %0d status %0d count %0d",
								want.granted, want.stat, want.count,
								granted_index, status, free_count);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				pool_capacity = capacity;
			if (in_valid && in_ready) begin
				want = predict_grant(operation, index);
				if (row_typed)
					want = row_want;
				awaited_grants = {awaited_grants, want};
			end
		end
	end

	task automatic send_request(input logic [1:0] op, input logic [IDX_W-1:0] idx,
			input bit typed = 1'b0, input grant_t want = '0);
		int gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		index <= idx;
		row_typed = typed;
		row_want = want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_grants.size() != 0) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		capacity <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_request(input int alloc_pct);
		logic [1:0] op;
		logic [IDX_W-1:0] idx;
		int r;
		r = $urandom_range(0, 99);
		idx = IDX_W'($urandom_range(0, 255));
		if (r < 3)
			op = OP_FREE_ALL;
		else if (r < 6)
			op = OP_NONE;
		else if ($urandom_range(0, 99) < alloc_pct)
			op = OP_ALLOC;
		else begin
			op = OP_FREE;
			// mostly in-range returns, some out of range
			if ($urandom_range(0, 4) != 0)
				idx = IDX_W'($urandom_range(0, pool_limit() - 1));
		end
		send_request(op, idx);
	endtask

	initial begin : stimulus
		logic [CNT_W-1:0] phase_caps [RANDOM_PHASES];
		int alloc_pct;
		phase_caps = '{9'd256, 9'd1, 9'd2, 9'd5, 9'd0, 9'd17, 9'd511, 9'd255, 9'd64, 9'd3};
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ALLOC;
		index = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		capacity = CAP_RESET;
		row_typed = 1'b0;
		row_want = '0;
		quiet_phase = 1'b0;
		error_count = 0;
		pool_capacity = CAP_RESET;
		pool_refill();

		directed_rows = '{
			chk_row(OP_FREE, 8'd5, 8'd0, ST_FULL, 9'd256),
			chk_row(OP_ALLOC, 8'd0, 8'd0, ST_OK, 9'd255),
			chk_row(OP_ALLOC, 8'd0, 8'd1, ST_OK, 9'd254),
			req_row(OP_FREE, 8'd255),
			req_row(OP_ALLOC, 8'd0),
			req_row(OP_NONE, 8'd255),
			chk_row(OP_FREE_ALL, 8'd0, 8'd0, ST_OK, 9'd256),
			cfg_row(9'd1),
			req_row(OP_FREE, 8'd0),
			chk_row(OP_FREE, 8'd1, 8'd0, ST_RANGE, 9'd256),
			chk_row(OP_FREE_ALL, 8'd0, 8'd0, ST_OK, 9'd1),
			chk_row(OP_ALLOC, 8'd0, 8'd0, ST_OK, 9'd0),
			chk_row(OP_ALLOC, 8'd0, 8'd0, ST_EMPTY, 9'd0),
			chk_row(OP_FREE, 8'd0, 8'd0, ST_OK, 9'd1),
			chk_row(OP_FREE, 8'd0, 8'd0, ST_FULL, 9'd1),
			cfg_row(9'd0),
			chk_row(OP_FREE_ALL, 8'd0, 8'd0, ST_OK, 9'd1),
			chk_row(OP_FREE, 8'd1, 8'd0, ST_RANGE, 9'd1),
			cfg_row(9'd511),
			chk_row(OP_FREE_ALL, 8'd0, 8'd0, ST_OK, 9'd256),
			chk_row(OP_FREE, 8'd255, 8'd0, ST_FULL, 9'd256),
			cfg_row(9'd3),
			req_row(OP_ALLOC, 8'd0),
			req_row(OP_FREE, 8'd200),
			req_row(OP_FREE, 8'd2),
			req_row(OP_FREE_ALL, 8'd0),
			req_row(OP_ALLOC, 8'd0),
			req_row(OP_FREE, 8'd1),
			req_row(OP_ALLOC, 8'd0),
			req_row(OP_ALLOC, 8'd0)
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_capacity(directed_rows[i].cap);
			else
				send_request(directed_rows[i].op, directed_rows[i].idx,
					directed_rows[i].typed, directed_rows[i].want);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_capacity(p == RANDOM_PHASES - 1 ? CNT_W'($urandom_range(0, 511)) :
				phase_caps[p]);
			quiet_phase = (p % 3 == 1);
			// leave some phases running on a stale list after a capacity change
			if (p % 4 != 3)
				send_request(OP_FREE_ALL, IDX_W'($urandom_range(0, 255)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((n < PHASE_ITEMS / 2) == (p % 2 == 0))
					alloc_pct = 70;
				else
					alloc_pct = 30;
				if (n == PHASE_ITEMS / 2 && p % 2 == 0)
					wait_drained();
				random_request(alloc_pct);
			end
		end
		quiet_phase = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && awaited_grants.size() == 0)
			$display("free_index_pool_allocator_top verification clean");
		else
			$display("free_index_pool_allocator_top verification failed");
		$finish;
	end

	// result side stalls
	initial begin : result_sink
		int stall;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("free_index_pool_allocator_top verification failed");
		$finish;
	end

endmodule
